// ===== hw/rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// Source code tokenizer package
// Shared constants, token record and character class helpers.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 24;
    localparam int OFFSET_BITS = 32;

    localparam int LEN_W  = (LENGTH_BITS > 16) ? 16 : LENGTH_BITS;
    localparam int LINE_W = (LINE_BITS > 24) ? 24 : LINE_BITS;

    localparam logic [2:0] ADDR_START_LINE = 3'd0;

    localparam logic [2:0] CLS_EOF   = 3'd0;
    localparam logic [2:0] CLS_RELOP = 3'd1;
    localparam logic [2:0] CLS_IDENT = 3'd2;
    localparam logic [2:0] CLS_NUM   = 3'd3;
    localparam logic [2:0] CLS_OP    = 3'd4;
    localparam logic [2:0] CLS_SEP   = 3'd5;
    localparam logic [2:0] CLS_WS    = 3'd6;
    localparam logic [2:0] CLS_ERR   = 3'd7;

    localparam logic [2:0] REL_LT     = 3'd0;
    localparam logic [2:0] REL_LE     = 3'd1;
    localparam logic [2:0] REL_EQ     = 3'd2;
    localparam logic [2:0] REL_ASSIGN = 3'd3;
    localparam logic [2:0] REL_GT     = 3'd4;
    localparam logic [2:0] REL_GE     = 3'd5;
    localparam logic [2:0] REL_NE     = 3'd6;

    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;

    localparam logic [2:0] SEP_SEMI   = 3'd0;
    localparam logic [2:0] SEP_COMMA  = 3'd1;
    localparam logic [2:0] SEP_LPAREN = 3'd2;
    localparam logic [2:0] SEP_RPAREN = 3'd3;
    localparam logic [2:0] SEP_LBRACE = 3'd4;
    localparam logic [2:0] SEP_RBRACE = 3'd5;
    localparam logic [2:0] SEP_LBRACK = 3'd6;
    localparam logic [2:0] SEP_RBRACK = 3'd7;

    localparam logic [2:0] KIND_NONE = 3'd0;

    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [2:0]  cls;
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [15:0] len;
        logic [31:0] start;
        logic [23:0] line;
        logic        last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] b);
        is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic token_t make_tok(input logic [2:0] cls, input logic [2:0] kind,
                                        input logic [7:0] ch, input logic [15:0] len,
                                        input logic [31:0] start, input logic [23:0] line);
        token_t t;
        t.cls   = cls;
        t.kind  = kind;
        t.ch    = ch;
        t.len   = len;
        t.start = start;
        t.line  = line;
        t.last  = 1'b0;
        make_tok = t;
    endfunction

endpackage

// ===== hw/rtl/source_code_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Source code tokenizer core
// Scans one source byte per item and emits up to two tokens per item.
// ----------------------------------------------------------------------------
// Each accepted item is held in an input register, then scanned; its tokens
// are written together into the token queue, which drives the output.
// Throughput: one item per cycle while the four-entry token queue has room for
// two tokens, bounded by its single output port when items give two tokens.
// Reset: scanner idle, offset and lengths zero, start line and line count 1.
module source_code_tokenizer_core
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_char, token_length, token_start, token_line
    output logic [5:0]  m_tuser,   // token_class, token_kind
    output logic        m_tlast,   // last_of_item
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_LT      = 4'd1;
    localparam logic [3:0] M_EQ      = 4'd2;
    localparam logic [3:0] M_GT      = 4'd3;
    localparam logic [3:0] M_BANG    = 4'd4;
    localparam logic [3:0] M_IDENT   = 4'd5;
    localparam logic [3:0] M_NUMBER  = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;
    localparam logic [3:0] M_STAR    = 4'd9;

    localparam logic [LEN_W-1:0]  LEN_CAP  = '1;
    localparam logic [LINE_W-1:0] LINE_CAP = '1;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eoi_reg;
    logic [3:0]             mode_reg, mode_next;
    logic [LEN_W-1:0]       plen_reg, plen_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [23:0]            start_line_reg;

    token_t                 fifo_reg [4];
    logic [1:0]             rd_ptr_reg;
    logic [1:0]             wr_ptr_reg;
    logic [2:0]             cnt_reg;

    token_t                 tok_a, tok_b;
    logic                   a_valid, b_valid;
    logic                   fire, pop, cfg_wr;
    logic [2:0]             cnt_after_pop;
    logic [1:0]             push_cnt;
    logic [7:0]             b;
    logic [31:0]            pos32, pstart32;
    logic [23:0]            line24;
    logic                   line_inc;
    logic [23:0]            cfg_line;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {8'b0, start_line_reg} : 32'b0;
    assign cfg_line = pwdata[23:0];

    assign pop           = m_tvalid && m_tready;
    assign cnt_after_pop = cnt_reg - {2'b0, pop};
    assign fire          = in_valid_reg && (cnt_after_pop <= 3'd2);
    assign s_tready      = !in_valid_reg || fire;

    assign b        = in_byte_reg;
    assign pos32    = 32'(pos_reg);
    assign pstart32 = 32'(pstart_reg);
    assign line24   = 24'(line_reg);

    always_comb
    begin
        token_t flush_tok;
        logic   flush_valid;

        mode_next   = mode_reg;
        plen_next   = plen_reg;
        pstart_next = pstart_reg;
        pos_next    = pos_reg;
        line_inc    = 1'b0;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        tok_a       = make_tok(CLS_EOF, KIND_NONE, 8'd0, 16'd0, pos32, line24);
        tok_b       = tok_a;

        flush_valid = 1'b1;
        unique case (mode_reg)
            M_LT:     flush_tok = make_tok(CLS_RELOP, REL_LT, 8'd0, 16'd1, pstart32, line24);
            M_EQ:     flush_tok = make_tok(CLS_RELOP, REL_ASSIGN, 8'd0, 16'd1, pstart32, line24);
            M_GT:     flush_tok = make_tok(CLS_RELOP, REL_GT, 8'd0, 16'd1, pstart32, line24);
            M_BANG:   flush_tok = make_tok(CLS_ERR, KIND_NONE, CH_BANG, 16'd1, pstart32, line24);
            M_IDENT:  flush_tok = make_tok(CLS_IDENT, KIND_NONE, 8'd0, 16'(plen_reg),
                                           pstart32, line24);
            M_NUMBER: flush_tok = make_tok(CLS_NUM, KIND_NONE, 8'd0, 16'(plen_reg),
                                           pstart32, line24);
            M_SLASH:  flush_tok = make_tok(CLS_OP, OP_DIV, CH_SLASH, 16'd1, pstart32, line24);
            default:
            begin
                flush_tok   = tok_a;
                flush_valid = 1'b0;
            end
        endcase

        if (in_eoi_reg)
        begin
            mode_next = M_IDLE;
            a_valid   = flush_valid;
            tok_a     = flush_tok;
            b_valid   = 1'b1;
        end
        else
        begin
            logic done;
            done     = 1'b1;
            pos_next = pos_reg + 1'b1;
            unique case (mode_reg)
                M_COMMENT:
                begin
                    if (b == CH_STAR)
                        mode_next = M_STAR;
                    else if (b == CH_NEWLINE)
                        line_inc = 1'b1;
                end
                M_STAR:
                begin
                    if (b == CH_SLASH)
                        mode_next = M_IDLE;
                    else if (b != CH_STAR)
                    begin
                        mode_next = M_COMMENT;
                        line_inc  = (b == CH_NEWLINE);
                    end
                end
                M_LT, M_EQ, M_GT, M_BANG:
                begin
                    if (b == CH_EQ)
                    begin
                        a_valid   = 1'b1;
                        mode_next = M_IDLE;
                        unique case (mode_reg)
                            M_LT:    tok_a = make_tok(CLS_RELOP, REL_LE, 8'd0, 16'd2,
                                                      pstart32, line24);
                            M_EQ:    tok_a = make_tok(CLS_RELOP, REL_EQ, 8'd0, 16'd2,
                                                      pstart32, line24);
                            M_GT:    tok_a = make_tok(CLS_RELOP, REL_GE, 8'd0, 16'd2,
                                                      pstart32, line24);
                            default: tok_a = make_tok(CLS_RELOP, REL_NE, 8'd0, 16'd2,
                                                      pstart32, line24);
                        endcase
                    end
                    else
                        done = 1'b0;
                end
                M_IDENT:
                begin
                    if (is_letter(b) || is_digit(b))
                    begin
                        if (plen_reg < LEN_CAP)
                            plen_next = plen_reg + 1'b1;
                    end
                    else
                        done = 1'b0;
                end
                M_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        if (plen_reg < LEN_CAP)
                            plen_next = plen_reg + 1'b1;
                    end
                    else
                        done = 1'b0;
                end
                M_SLASH:
                begin
                    if (b == CH_STAR)
                        mode_next = M_COMMENT;
                    else
                        done = 1'b0;
                end
                default:
                    done = 1'b0;
            endcase

            if (!done)
            begin
                a_valid     = flush_valid;
                tok_a       = flush_tok;
                pstart_next = pos_reg;
                plen_next   = LEN_W'(1);
                mode_next   = M_IDLE;
                b_valid     = 1'b1;
                tok_b       = make_tok(CLS_WS, KIND_NONE, b, 16'd1, pos32, line24);
                priority case (1'b1)
                    (b == CH_LT):     begin mode_next = M_LT;    b_valid = 1'b0; end
                    (b == CH_EQ):     begin mode_next = M_EQ;    b_valid = 1'b0; end
                    (b == CH_GT):     begin mode_next = M_GT;    b_valid = 1'b0; end
                    (b == CH_BANG):   begin mode_next = M_BANG;  b_valid = 1'b0; end
                    (b == CH_SLASH):  begin mode_next = M_SLASH; b_valid = 1'b0; end
                    (b == CH_PLUS):   begin tok_b.cls = CLS_OP;  tok_b.kind = OP_PLUS;  end
                    (b == CH_MINUS):  begin tok_b.cls = CLS_OP;  tok_b.kind = OP_MINUS; end
                    (b == CH_STAR):   begin tok_b.cls = CLS_OP;  tok_b.kind = OP_MUL;   end
                    (b == CH_SEMI):   begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_SEMI;   end
                    (b == CH_COMMA):  begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_COMMA;  end
                    (b == CH_LPAREN): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_LPAREN; end
                    (b == CH_RPAREN): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_RPAREN; end
                    (b == CH_LBRACE): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_LBRACE; end
                    (b == CH_RBRACE): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_RBRACE; end
                    (b == CH_LBRACK): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_LBRACK; end
                    (b == CH_RBRACK): begin tok_b.cls = CLS_SEP; tok_b.kind = SEP_RBRACK; end
                    is_letter(b):     begin mode_next = M_IDENT;  b_valid = 1'b0; end
                    is_digit(b):      begin mode_next = M_NUMBER; b_valid = 1'b0; end
                    default:          line_inc = (b == CH_NEWLINE);
                endcase
            end
        end

        if (b_valid)
            tok_b.last = 1'b1;
        else
            tok_a.last = 1'b1;

        if (line_inc && (line_reg < LINE_CAP))
            line_next = line_reg + 1'b1;
        else
            line_next = line_reg;
    end

    assign push_cnt = fire ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            mode_reg       <= M_IDLE;
            plen_reg       <= '0;
            pstart_reg     <= '0;
            pos_reg        <= '0;
            line_reg       <= LINE_W'(1);
            start_line_reg <= 24'd1;
            rd_ptr_reg     <= 2'd0;
            wr_ptr_reg     <= 2'd0;
            cnt_reg        <= 3'd0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                mode_reg   <= mode_next;
                plen_reg   <= plen_next;
                pstart_reg <= pstart_next;
                pos_reg    <= pos_next;
            end
            if (cfg_wr)
            begin
                start_line_reg <= cfg_line;
                line_reg <= (cfg_line > 24'(LINE_CAP)) ? LINE_CAP : LINE_W'(cfg_line);
            end
            else if (fire)
                line_reg <= line_next;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            cnt_reg    <= cnt_after_pop + {1'b0, push_cnt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
        if (fire)
        begin
            if (a_valid)
            begin
                fifo_reg[wr_ptr_reg] <= tok_a;
                if (b_valid)
                    fifo_reg[wr_ptr_reg + 2'd1] <= tok_b;
            end
            else if (b_valid)
                fifo_reg[wr_ptr_reg] <= tok_b;
        end
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {fifo_reg[rd_ptr_reg].line, fifo_reg[rd_ptr_reg].start,
                       fifo_reg[rd_ptr_reg].len, fifo_reg[rd_ptr_reg].ch};
    assign m_tuser  = {fifo_reg[rd_ptr_reg].kind, fifo_reg[rd_ptr_reg].cls};
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("token queue count out of range");

    a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eoi_reg |=> cnt_reg != 3'd0)
        else $error("end of input left no token queued");

    a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eoi_reg |=> mode_reg == M_IDLE)
        else $error("scanner not idle after end of input");

    a_eof_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eoi_reg |=> $stable(pos_reg))
        else $error("offset moved on end of input");

endmodule
